[rtl/hfcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfcs_pkg
// shared widths, codes and saturating helpers of the forward column step
// ----------------------------------------------------------------------------
package hfcs_pkg;

   localparam int VALUE_W            = 40;
   localparam int PROB_W             = 32;
   localparam int IDX_W              = 5;
   localparam int SCALE_W            = 32;
   localparam int SHIFT_W            = 6;
   localparam int NUM_STATES_DEF     = 16;
   localparam int FRACTION_BITS_DEF  = 32;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // input item kinds
   localparam logic [1:0] MODE_LOAD_TRANS = 2'd0;
   localparam logic [1:0] MODE_LOAD_START = 2'd1;
   localparam logic [1:0] MODE_COLUMN     = 2'd2;

   // register indexes
   localparam logic [1:0] REG_EMIT_MASK   = 2'd0;
   localparam logic [1:0] REG_END_STATE   = 2'd1;
   localparam logic [1:0] REG_CUTOFF      = 2'd2;

   localparam logic [4:0] CUTOFF_RESET    = 5'd16;

   // control of the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic term_valid;
   } mac_ctl_type;

   // saturating add of two values
   function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VALUE_W] ? VALUE_MAX : s[VALUE_W-1:0];
   endfunction

   // saturating left shift
   function automatic logic [VALUE_W-1:0] sat_shl(input logic [VALUE_W-1:0] v,
                                                  input logic [SHIFT_W-1:0] sh);
      logic [2*VALUE_W-1:0] w;
      w = {{VALUE_W{1'b0}}, v} << sh;
      if (v == '0)
         return '0;
      else if (sh >= SHIFT_W'(VALUE_W) || w[2*VALUE_W-1:VALUE_W] != '0)
         return VALUE_MAX;
      else
         return w[VALUE_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/hmm_forward_column_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_forward_column_step
// forward recursion of a constrained hmm, one column per beat, block float
// ----------------------------------------------------------------------------
// load beats write one table entry. the input is not ready while a column
//   is scanned, summed, rescaled when the maximum falls below the cutoff,
//   totalled and sent; allowed states that sum share one mac (one transition
//   ram read per cycle), emitting states of a first column take the start table.
// at most one result beat per cycle, while rsp_tready allows.
// synchronous reset clears the previous mask, exponent and registers.
// ----------------------------------------------------------------------------
module hmm_forward_column_step #(
   parameter int NUM_STATES    = hfcs_pkg::NUM_STATES_DEF,
   parameter int FRACTION_BITS = hfcs_pkg::FRACTION_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // from_state, to_state, prob_value, allowed_mask, zero fill
   input  wire logic [79:0]  req_tdata,
   // mode, first_column
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // state_index, state_value, column_scale, column_total, zero fill
   output logic      [119:0] rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import hfcs_pkg::*;

   localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int CW  = SW + 1;
   localparam int TW  = $clog2(NUM_STATES * NUM_STATES);
   localparam int SL  = (FRACTION_BITS >= 32) ? FRACTION_BITS - 32 : 0;
   localparam int SR  = (FRACTION_BITS < 32) ? 32 - FRACTION_BITS : 0;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_SCAN   = 11'b00000000010,
      ST_START  = 11'b00000000100,
      ST_MAC    = 11'b00000001000,
      ST_DRAIN  = 11'b00000010000,
      ST_CHECK  = 11'b00000100000,
      ST_NORM   = 11'b00001000000,
      ST_SHIFT  = 11'b00010000000,
      ST_TOTAL  = 11'b00100000000,
      ST_TDRAIN = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] emit_mask_ff;
   logic [4:0]  end_state_ff;
   logic [4:0]  cutoff_ff;

   // column context
   logic [NUM_STATES-1:0] allowed_ff, allowed_in;
   logic [NUM_STATES-1:0] prev_allowed_ff, prev_allowed_in;
   logic                  first_ff, first_in;
   logic                  bank_ff, bank_in;
   logic signed [SCALE_W-1:0] exp_ff, exp_in;
   logic [VALUE_W-1:0]    max_ff, max_in;
   logic [VALUE_W-1:0]    total_ff, total_in;
   logic [CW-1:0]         s_ff, s_in;
   logic [CW-1:0]         t_ff, t_in;
   logic [1:0]            cnt_ff, cnt_in;

   // column values, two banks swapped at column end
   logic [VALUE_W-1:0]    col_ff [2][NUM_STATES];
   logic                  col_we;
   logic [VALUE_W-1:0]    col_wdata;
   logic [VALUE_W-1:0]    rdval_ff;
   logic                  rd_bank;
   logic [SW-1:0]         rd_idx;
   logic                  term_in, term_ff;

   // request fields
   logic [1:0]  req_mode;
   logic        req_first;
   logic [4:0]  req_from, req_to;
   logic [31:0] req_prob, req_allowed;
   logic        req_fire;

   // rams
   logic          trans_we, start_we;
   logic [TW-1:0] trans_waddr, trans_raddr;
   logic [SW-1:0] start_waddr;
   logic [31:0]   trans_q, start_q;

   // helpers
   logic [SW-1:0]      s_idx, t_idx;
   logic               s_emit, s_allowed, end_ok;
   logic [VALUE_W-1:0] start_val, mac_acc, cur_val, shifted;
   logic [SHIFT_W-1:0] lz;
   logic               norm_done, norm_start;
   logic               rescale;
   logic [63:0]        threshold;
   logic signed [SCALE_W:0] exp_dec;
   mac_ctl_type        mac_ctl;
   logic               rsp_load, rsp_last;
   logic [NUM_STATES:0] above;

   logic [4:0]          rsp_index_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [SCALE_W-1:0]  rsp_scale_ff;
   logic [VALUE_W-1:0]  rsp_total_ff;
   logic                rsp_last_ff;
   logic                rsp_valid_ff;

   // unpack request beat
   assign req_mode    = req_tuser[1:0];
   assign req_first   = req_tuser[2];
   assign req_from    = req_tdata[4:0];
   assign req_to      = req_tdata[9:5];
   assign req_prob    = req_tdata[41:10];
   assign req_allowed = req_tdata[73:42];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_mask_ff <= '0;
         end_state_ff <= '0;
         cutoff_ff    <= CUTOFF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_EMIT_MASK: emit_mask_ff <= csr_data;
            REG_END_STATE: end_state_ff <= csr_data[4:0];
            REG_CUTOFF:    cutoff_ff    <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // table loads
   always_comb begin
      trans_we    = req_fire && req_mode == MODE_LOAD_TRANS &&
                    6'(req_from) < 6'(NUM_STATES) && 6'(req_to) < 6'(NUM_STATES);
      start_we    = req_fire && req_mode == MODE_LOAD_START &&
                    6'(req_from) < 6'(NUM_STATES);
      trans_waddr = TW'(req_from[SW-1:0]) * TW'(NUM_STATES) + TW'(req_to[SW-1:0]);
      start_waddr = req_from[SW-1:0];
   end

   hfcs_ram #(.WIDTH(PROB_W), .DEPTH(NUM_STATES * NUM_STATES)) u_trans_ram (
      .clock   (clock),
      .wr_en   (trans_we),
      .wr_addr (trans_waddr),
      .wr_data (req_prob),
      .rd_addr (trans_raddr),
      .rd_data (trans_q)
   );

   hfcs_ram #(.WIDTH(PROB_W), .DEPTH(NUM_STATES)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (start_waddr),
      .wr_data (req_prob),
      .rd_addr (s_idx),
      .rd_data (start_q)
   );

   // per-state decode
   always_comb begin
      s_idx     = s_ff[SW-1:0];
      t_idx     = t_ff[SW-1:0];
      s_emit    = emit_mask_ff[s_idx];
      s_allowed = allowed_ff[s_idx];
      end_ok    = 6'(end_state_ff) < 6'(NUM_STATES);
      cur_val   = col_ff[bank_ff][s_idx];
      shifted   = sat_shl(cur_val, lz);
      start_val = (FRACTION_BITS >= 32) ? sat_shl(VALUE_W'(start_q), SHIFT_W'(SL))
                                        : VALUE_W'(start_q >> SR);
      threshold = 64'(1) << (SHIFT_W'(FRACTION_BITS) - SHIFT_W'(cutoff_ff));
      rescale   = max_ff != '0 && 6'(cutoff_ff) <= 6'(FRACTION_BITS) &&
                  64'(max_ff) < threshold;
      exp_dec   = (SCALE_W+1)'(exp_ff) - (SCALE_W+1)'(signed'({1'b0, lz}));
      above     = (NUM_STATES+1)'(allowed_ff) >> (s_ff + 1'b1);
   end

   // transition read address and mac operand selection
   always_comb begin
      if (state_ff == ST_MAC) begin
         trans_raddr = TW'(t_idx) * TW'(NUM_STATES) + TW'(s_idx);
         rd_idx      = t_idx;
         rd_bank     = s_emit ? ~bank_ff : bank_ff;
         term_in     = s_emit ? prev_allowed_ff[t_idx]
                              : (allowed_ff[t_idx] && t_ff < s_ff);
      end else begin
         trans_raddr = TW'(s_idx) * TW'(NUM_STATES) + TW'(end_state_ff[SW-1:0]);
         rd_idx      = s_idx;
         rd_bank     = bank_ff;
         term_in     = (state_ff == ST_TOTAL) && s_allowed && end_ok;
      end
   end

   // operand register aligned with the ram read
   always_ff @(posedge clock) begin
      rdval_ff <= col_ff[rd_bank][rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= 1'b0;
      end else begin
         term_ff <= term_in;
      end
   end

   hfcs_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .value (rdval_ff),
      .prob  (trans_q),
      .acc   (mac_acc)
   );

   hfcs_norm #(.FRACTION_BITS(FRACTION_BITS)) u_norm (
      .clock   (clock),
      .start   (norm_start),
      .maximum (max_ff),
      .done    (norm_done),
      .lz      (lz)
   );

   // column value write port
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_ff[bank_ff][s_idx] <= col_wdata;
      end
   end

   // column sequencer
   always_comb begin
      state_in        = state_ff;
      allowed_in      = allowed_ff;
      prev_allowed_in = prev_allowed_ff;
      first_in        = first_ff;
      bank_in         = bank_ff;
      exp_in          = exp_ff;
      max_in          = max_ff;
      total_in        = total_ff;
      s_in            = s_ff;
      t_in            = t_ff;
      cnt_in          = cnt_ff;
      col_we          = 1'b0;
      col_wdata       = mac_acc;
      mac_ctl.clear      = 1'b0;
      mac_ctl.term_valid = term_ff;
      norm_start      = 1'b0;
      rsp_load        = 1'b0;
      rsp_last        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_mode == MODE_COLUMN) begin
               allowed_in = req_allowed[NUM_STATES-1:0];
               first_in   = req_first;
               max_in     = '0;
               s_in       = '0;
               if (req_first) begin
                  exp_in = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (s_ff == CW'(NUM_STATES)) begin
               state_in = ST_CHECK;
            end else if (!s_allowed) begin
               s_in = s_ff + 1'b1;
            end else if (s_emit && first_ff) begin
               state_in = ST_START;
            end else begin
               mac_ctl.clear = 1'b1;
               t_in          = '0;
               state_in      = ST_MAC;
            end
         end
         ST_START: begin
            col_we    = 1'b1;
            col_wdata = start_val;
            s_in      = s_ff + 1'b1;
            state_in  = ST_SCAN;
         end
         ST_MAC: begin
            if (t_ff == CW'(NUM_STATES - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd2) begin
               col_we = 1'b1;
               if (mac_acc > max_ff) begin
                  max_in = mac_acc;
               end
               s_in     = s_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_CHECK: begin
            s_in = '0;
            if (rescale) begin
               norm_start = 1'b1;
               state_in   = ST_NORM;
            end else begin
               mac_ctl.clear = 1'b1;
               state_in      = ST_TOTAL;
            end
         end
         ST_NORM: begin
            if (norm_done) begin
               exp_in   = (exp_dec < -(SCALE_W+1)'(64'sd2147483648)) ?
                          {1'b1, {(SCALE_W-1){1'b0}}} : exp_dec[SCALE_W-1:0];
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            col_we    = s_allowed;
            col_wdata = shifted;
            if (s_ff == CW'(NUM_STATES - 1)) begin
               s_in          = '0;
               mac_ctl.clear = 1'b1;
               state_in      = ST_TOTAL;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_TOTAL: begin
            if (s_ff == CW'(NUM_STATES - 1)) begin
               cnt_in   = '0;
               state_in = ST_TDRAIN;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_TDRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd2) begin
               total_in = mac_acc;
               s_in     = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (s_ff == CW'(NUM_STATES)) begin
               bank_in         = ~bank_ff;
               prev_allowed_in = allowed_ff;
               state_in        = ST_IDLE;
            end else if (!s_allowed) begin
               s_in = s_ff + 1'b1;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               rsp_last = (above == '0);
               s_in     = s_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         prev_allowed_ff <= '0;
         bank_ff         <= 1'b0;
         exp_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         prev_allowed_ff <= prev_allowed_in;
         bank_ff         <= bank_in;
         exp_ff          <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      allowed_ff <= allowed_in;
      first_ff   <= first_in;
      max_ff     <= max_in;
      total_ff   <= total_in;
      s_ff       <= s_in;
      t_ff       <= t_in;
      cnt_ff     <= cnt_in;
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= 5'(s_idx);
         rsp_value_ff <= cur_val;
         rsp_scale_ff <= exp_ff;
         rsp_total_ff <= rsp_last ? total_ff : '0;
         rsp_last_ff  <= rsp_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_scale_ff, rsp_value_ff, rsp_index_ff};

endmodule
`default_nettype wire

[rtl/hfcs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfcs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hfcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/hfcs_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfcs_mac
// two stage value times probability multiply with saturating accumulate
// ----------------------------------------------------------------------------
module hfcs_mac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hfcs_pkg::mac_ctl_type         ctl,
   input  wire logic [hfcs_pkg::VALUE_W-1:0]  value,
   input  wire logic [hfcs_pkg::PROB_W-1:0]   prob,
   output logic      [hfcs_pkg::VALUE_W-1:0]  acc
);
   import hfcs_pkg::*;

   localparam int HI_W = VALUE_W - 32;

   logic [HI_W+PROB_W-1:0] hi_prod_ff;
   logic [32+PROB_W-1:0]   lo_prod_ff;
   logic                   valid_ff;
   logic [VALUE_W-1:0]     acc_ff;
   logic [VALUE_W:0]       term_sum;
   logic [VALUE_W-1:0]     term;

   // stage one: split partial products
   always_ff @(posedge clock) begin
      hi_prod_ff <= value[VALUE_W-1:32] * prob;
      lo_prod_ff <= value[31:0] * prob;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.term_valid;
      end
   end

   // recombine, truncate below the binary point, saturate
   always_comb begin
      term_sum = (VALUE_W+1)'(hi_prod_ff) + (VALUE_W+1)'(lo_prod_ff[63:32]);
      term     = term_sum[VALUE_W] ? VALUE_MAX : term_sum[VALUE_W-1:0];
   end

   // stage two: accumulate
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (valid_ff) begin
         acc_ff <= sat_add(acc_ff, term);
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

[rtl/hfcs_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfcs_norm
// iterative leading-zero count of the column maximum, one bit per cycle
// ----------------------------------------------------------------------------
module hfcs_norm #(
   parameter int FRACTION_BITS = hfcs_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          start,
   input  wire logic [hfcs_pkg::VALUE_W-1:0]  maximum,
   output logic                               done,
   output logic      [hfcs_pkg::SHIFT_W-1:0]  lz
);
   import hfcs_pkg::*;

   localparam int NW = (FRACTION_BITS > VALUE_W) ? FRACTION_BITS : VALUE_W;

   logic [NW-1:0]      m_ff;
   logic [SHIFT_W-1:0] lz_ff;

   // shift until the top fraction bit is set
   always_ff @(posedge clock) begin
      if (start) begin
         m_ff  <= NW'(maximum);
         lz_ff <= '0;
      end else if (!m_ff[FRACTION_BITS-1]) begin
         m_ff  <= m_ff << 1;
         lz_ff <= lz_ff + 1'b1;
      end
   end

   assign done = m_ff[FRACTION_BITS-1];
   assign lz   = lz_ff;

endmodule
`default_nettype wire
